>>> rtl/core/indexed_min_heap_queue_unit_assert.svh
// Assertion macros for the indexed min-heap queue unit.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define IMHQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("imhq: property violated");
// Check that a condition never holds outside reset.
`define IMHQ_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("imhq: forbidden condition seen");
`else
`define IMHQ_ASSERT(lbl, prop)
`define IMHQ_NEVER(lbl, cond)
`endif

`endif

>>> rtl/core/imhq_pkg.sv
// Shared types and constants of the indexed min-heap queue unit.
package imhq_pkg;

  localparam int VTX_BITS  = 6;
  localparam int VTX_COUNT = 64;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_EXT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP
  } state_e;

endpackage

>>> rtl/core/indexed_min_heap_queue_unit.sv
// Indexed binary min-heap with per-vertex position map and a read/compare/move sequencer.
//
//  channel  | handshake          | fields
//  ---------+--------------------+-------------------------------------------------
//  command  | start_i, busy_o    | cmd_i, vertex_i, distance_i
//  result   | done_o (1 cycle)   | out_vertex_o, out_distance_o, status_o, occupancy_o
//
// An insert lets its entry climb level by level towards the root, and an extract lets the
// moved last entry sink level by level from the root.
// Each level is a heap memory read state followed by a compare/move state.
// Reset is asynchronous and active low; vertex valid bits clear at once, no clearing pass.
// The result is shown for one cycle with done_o; the receiver cannot stall it.
`include "indexed_min_heap_queue_unit_assert.svh"

module indexed_min_heap_queue_unit #(
  parameter int HEAP_DEPTH = 64,
  parameter int DIST_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               cmd_i,
  input  logic [imhq_pkg::VTX_BITS-1:0]      vertex_i,
  input  logic [DIST_BITS-1:0]               distance_i,
  output logic                               done_o,
  output logic [imhq_pkg::VTX_BITS-1:0]      out_vertex_o,
  output logic [DIST_BITS-1:0]               out_distance_o,
  output logic [1:0]                         status_o,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]    occupancy_o
);
  import imhq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = AW + 2;

  typedef struct packed {
    logic [VTX_BITS-1:0]  vtx;
    logic [DIST_BITS-1:0] key;
  } entry_t;

  // Storage
  entry_t            heap_mem [HEAP_DEPTH];
  logic [AW-1:0]     pos_mem  [VTX_COUNT];
  logic [VTX_COUNT-1:0] valid_q, valid_d;

  // Control and datapath registers
  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] at_q, at_d;
  entry_t        s_q, s_d;
  logic          ins_q;
  logic [VTX_BITS-1:0] vtx_q;
  logic          done_q, done_d;
  entry_t        res_q, res_d;
  status_e       res_status_q, res_status_d;
  logic [CW-1:0] res_count_q, res_count_d;

  // Memory ports
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  entry_t        rd_a_q, rd_b_q;
  logic [AW-1:0] pos_rd_q;
  logic          heap_we;
  logic [AW-1:0] heap_waddr;
  entry_t        heap_wdata;
  logic          pos_we;
  logic [VTX_BITS-1:0] pos_waddr;
  logic [AW-1:0] pos_wdata;

  // Tree navigation
  logic [AW-1:0] up_idx;
  logic [XW-1:0] lc_x, rc_x, count_x;
  logic          l_ok, r_ok, take_l, take_r;
  logic [DIST_BITS-1:0] best_dist;
  logic [CW-1:0] last_cnt;

  assign up_idx   = (at_q - AW'(1)) >> 1;
  assign lc_x     = XW'({at_q, 1'b1});
  assign rc_x     = lc_x + XW'(1);
  assign count_x  = XW'(count_q);
  assign l_ok     = lc_x < count_x;
  assign r_ok     = rc_x < count_x;
  assign last_cnt = count_q - CW'(1);

  // Pick the smaller child, left wins ties
  always_comb begin
    take_l    = l_ok && (rd_a_q.key < s_q.key);
    best_dist = take_l ? rd_a_q.key : s_q.key;
    take_r    = r_ok && (rd_b_q.key < best_dist);
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  // Position map memory: slot index of each queued vertex
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_q <= pos_mem[vertex_i];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    at_q         <= at_d;
    s_q          <= s_d;
    res_q        <= res_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    if (state_q == ST_IDLE && start_i) begin
      ins_q <= (cmd_i == CMD_INSERT);
      vtx_q <= vertex_i;
    end
  end

  // Sequencer: next state, memory requests and result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    valid_d      = valid_q;
    at_d         = at_q;
    s_d          = s_q;
    done_d       = 1'b0;
    res_d        = res_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    rd_a_addr    = '0;
    rd_b_addr    = last_cnt[AW-1:0];
    heap_we      = 1'b0;
    heap_waddr   = at_q;
    heap_wdata   = s_q;
    pos_we       = 1'b0;
    pos_waddr    = s_q.vtx;
    pos_wdata    = at_q;

    case (state_q)
      ST_IDLE: begin
        // Fetch root, last entry and position while the command is taken
        if (start_i) begin
          s_d.vtx  = vertex_i;
          s_d.key  = distance_i;
          state_d  = (cmd_i == CMD_INSERT) ? ST_INS : ST_EXT;
        end
      end
      ST_INS: begin
        res_d = '0;
        if (valid_q[vtx_q] && (CW'(pos_rd_q) < count_q)) begin
          at_d    = pos_rd_q;
          state_d = ST_UP_RD;
        end else if (count_q == CW'(HEAP_DEPTH)) begin
          res_status_d = STAT_FULL;
          res_count_d  = count_q;
          done_d       = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          at_d    = count_q[AW-1:0];
          count_d = count_q + CW'(1);
          state_d = ST_UP_RD;
        end
      end
      ST_EXT: begin
        if (count_q == '0) begin
          res_d        = '0;
          res_status_d = STAT_EMPTY;
          res_count_d  = count_q;
          done_d       = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          // Drop the root and sink the last entry from the top
          res_d               = rd_a_q;
          res_status_d        = STAT_OK;
          res_count_d         = last_cnt;
          valid_d[rd_a_q.vtx] = 1'b0;
          count_d             = last_cnt;
          s_d                 = rd_b_q;
          at_d                = '0;
          if (last_cnt == '0) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DN_RD;
          end
        end
      end
      ST_UP_RD: begin
        if (at_q == '0) begin
          heap_we          = 1'b1;
          pos_we           = 1'b1;
          valid_d[s_q.vtx] = 1'b1;
          res_status_d     = STAT_OK;
          res_count_d      = count_q;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          rd_a_addr = up_idx;
          state_d   = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (s_q.key < rd_a_q.key) begin
          // Pull the parent down into the hole
          heap_wdata = rd_a_q;
          pos_waddr  = rd_a_q.vtx;
          at_d       = up_idx;
          state_d    = ST_UP_RD;
        end else begin
          valid_d[s_q.vtx] = 1'b1;
          res_status_d     = STAT_OK;
          res_count_d      = count_q;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_DN_RD: begin
        rd_a_addr = lc_x[AW-1:0];
        rd_b_addr = rc_x[AW-1:0];
        state_d   = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (take_r) begin
          heap_wdata = rd_b_q;
          pos_waddr  = rd_b_q.vtx;
          at_d       = rc_x[AW-1:0];
          state_d    = ST_DN_RD;
        end else if (take_l) begin
          heap_wdata = rd_a_q;
          pos_waddr  = rd_a_q.vtx;
          at_d       = lc_x[AW-1:0];
          state_d    = ST_DN_RD;
        end else begin
          valid_d[s_q.vtx] = 1'b1;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign out_vertex_o   = res_q.vtx;
  assign out_distance_o = res_q.key;
  assign status_o       = res_status_q;
  assign occupancy_o    = res_count_q;

  `IMHQ_ASSERT(a_done_when_idle, done_q |-> (state_q == ST_IDLE))
  `IMHQ_NEVER(a_count_in_range, count_q > CW'(HEAP_DEPTH))
  `IMHQ_ASSERT(a_full_only_at_depth, (done_q && res_status_q == STAT_FULL) |-> (res_count_q == CW'(HEAP_DEPTH)))
  `IMHQ_ASSERT(a_empty_only_at_zero, (done_q && res_status_q == STAT_EMPTY) |-> (res_count_q == '0))
  `IMHQ_ASSERT(a_insert_zero_fields, (done_q && ins_q) |-> (res_q == '0))
  `IMHQ_ASSERT(a_start_goes_busy, (start_i && !busy_o) |=> busy_o)

endmodule
